/* hw/rtl/i2c_seq_pkg.sv */
// ----------------------------------------------------------------------------
// i2c_seq_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2c_seq_pkg;

    // Command codes; code 7 is unused and treated like none.
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_START  = 3'd1,
        OP_RSTART = 3'd2,
        OP_STOP   = 3'd3,
        OP_WRITE  = 3'd4,
        OP_ADDR   = 3'd5,
        OP_READ   = 3'd6
    } t_op;

    localparam int unsigned STEP_W = 5;

    // Last step of each sequence
    localparam logic [STEP_W-1:0] LAST_START_STEP = 5'd2;
    localparam logic [STEP_W-1:0] LAST_RS_STEP    = 5'd3;  // repeated start and stop
    localparam logic [STEP_W-1:0] BIT_STEPS       = 5'd24; // 8 bits x 3 steps
    localparam logic [STEP_W-1:0] ACK_SCL_LO_STEP = 5'd24;
    localparam logic [STEP_W-1:0] ACK_SDA_STEP    = 5'd25;
    localparam logic [STEP_W-1:0] ACK_SCL_HI_STEP = 5'd26;
    localparam logic [STEP_W-1:0] LAST_WRITE_STEP = 5'd27;
    localparam logic [STEP_W-1:0] LAST_READ_STEP  = 5'd28;

    localparam logic [1:0] PHASE_LAST = 2'd2;

    localparam int unsigned IN_W  = 24;
    localparam int unsigned OUT_W = 16;

endpackage

/* hw/rtl/i2c_master_bit_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Tick-driven I2C master: one input beat is one line step.
// ----------------------------------------------------------------------------
// Every input beat is one line step and produces exactly one output beat with
// the SCL/SDA drive levels after that step, busy/done flags, the last ACK
// sample and the last read byte. A command (start, repeated start, stop,
// write byte, address, read byte) is taken only while no sequence runs; its
// first step happens on the same beat, and later beats (with any op) advance
// it. Write and address take 28 steps, read takes 29, start 3, repeated start
// and stop 4. Throughput is one beat per clock while the output is not
// stalled: an input register feeds the step logic, and the result lands in an
// output register, so a result beat is valid once its input beat has passed
// through both registers; a stalled output beat holds the input register and
// drops tready until it leaves. The sequencer state updates when a beat moves
// from the input register to the output register.
module i2c_master_bit_sequencer
    import i2c_seq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [2:0] op, [10:3] write_data, [17:11] target_addr, [18] read_flag,
    // [19] send_nack, [20] sda_in, [23:21] zero
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] ack_error,
    // [12:5] read_data, [15:13] zero
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    // ---------------- input register ----------------
    logic             r_in_valid;
    logic [2:0]       r_in_op;
    logic [7:0]       r_in_wdata;
    logic [6:0]       r_in_addr;
    logic             r_in_rflag;
    logic             r_in_nack;
    logic             r_in_sda;

    // ---------------- output register ----------------
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    // ---------------- sequencer state ----------------
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    t_op               r_cmd, n_cmd;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_phase, n_phase;  // step index mod 3 during the bit loop
    logic [7:0]        r_shift, n_shift;
    logic              r_nack, n_nack;
    logic              r_ack, n_ack;
    logic [7:0]        r_rd_hold, n_rd_hold;
    logic              n_done;

    logic adv;   // input beat moves into the output register

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Control side of the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // Payload side, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op    <= i_s_axis_tdata[2:0];
            r_in_wdata <= i_s_axis_tdata[10:3];
            r_in_addr  <= i_s_axis_tdata[17:11];
            r_in_rflag <= i_s_axis_tdata[18];
            r_in_nack  <= i_s_axis_tdata[19];
            r_in_sda   <= i_s_axis_tdata[20];
        end
    end

    // One line step
    always_comb begin
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_cmd     = r_cmd;
        n_step    = r_step;
        n_phase   = r_phase;
        n_shift   = r_shift;
        n_nack    = r_nack;
        n_ack     = r_ack;
        n_rd_hold = r_rd_hold;
        n_done    = 1'b0;

        // Command launch only when idle; code 7 falls through as none
        if (r_cmd == OP_NONE) begin
            n_step  = '0;
            n_phase = '0;
            case (r_in_op)
                OP_START, OP_RSTART, OP_STOP: begin
                    n_cmd = t_op'(r_in_op);
                end
                OP_WRITE: begin
                    n_cmd   = OP_WRITE;
                    n_shift = r_in_wdata;
                end
                OP_ADDR: begin
                    n_cmd   = OP_ADDR;
                    n_shift = {r_in_addr, r_in_rflag};
                end
                OP_READ: begin
                    n_cmd   = OP_READ;
                    n_shift = '0;
                    n_nack  = r_in_nack;
                end
                default: begin
                    n_cmd = OP_NONE;
                end
            endcase
        end

        unique case (n_cmd)
            OP_NONE: begin
            end
            OP_START: begin
                if (n_step == 5'd0)      n_sda = 1'b1;
                else if (n_step == 5'd1) n_scl = 1'b1;
                else                     n_sda = 1'b0;
                n_done = (n_step >= LAST_START_STEP);
            end
            OP_RSTART: begin
                if (n_step == 5'd0)      n_scl = 1'b0;
                else if (n_step == 5'd1) n_sda = 1'b1;
                else if (n_step == 5'd2) n_scl = 1'b1;
                else                     n_sda = 1'b0;
                n_done = (n_step >= LAST_RS_STEP);
            end
            OP_STOP: begin
                if (n_step == 5'd0)      n_scl = 1'b0;
                else if (n_step == 5'd1) n_sda = 1'b0;
                else if (n_step == 5'd2) n_scl = 1'b1;
                else                     n_sda = 1'b1;
                n_done = (n_step >= LAST_RS_STEP);
            end
            OP_WRITE, OP_ADDR: begin
                if (n_step < BIT_STEPS) begin
                    // MSB first; byte shifts left after each SCL rise
                    case (n_phase)
                        2'd0:    n_scl = 1'b0;
                        2'd1:    n_sda = n_shift[7];
                        default: begin
                            n_scl   = 1'b1;
                            n_shift = {n_shift[6:0], 1'b0};
                        end
                    endcase
                end else if (n_step == ACK_SCL_LO_STEP) begin
                    n_scl = 1'b0;
                end else if (n_step == ACK_SDA_STEP) begin
                    n_sda = 1'b1;
                end else if (n_step == ACK_SCL_HI_STEP) begin
                    n_scl = 1'b1;
                end else begin
                    n_ack = r_in_sda;
                end
                n_done = (n_step >= LAST_WRITE_STEP);
            end
            OP_READ: begin
                if (n_step < BIT_STEPS) begin
                    case (n_phase)
                        2'd0:    n_scl = 1'b0;
                        2'd1:    n_scl = 1'b1;
                        default: n_shift = {n_shift[6:0], r_in_sda};
                    endcase
                end else if (n_step == ACK_SCL_LO_STEP) begin
                    n_scl = 1'b0;
                end else if (n_step == ACK_SDA_STEP) begin
                    n_sda = n_nack;
                end else if (n_step == ACK_SCL_HI_STEP) begin
                    n_scl = 1'b1;
                end else if (n_step == LAST_WRITE_STEP) begin
                    n_scl = 1'b0;
                end else begin
                    n_sda     = 1'b1;
                    n_rd_hold = n_shift;
                end
                n_done = (n_step >= LAST_READ_STEP);
            end
            default: begin
                n_done = 1'b1;
            end
        endcase

        // Advance or retire
        if (n_cmd != OP_NONE) begin
            if (n_done) begin
                n_cmd   = OP_NONE;
                n_step  = '0;
                n_phase = '0;
            end else begin
                n_step  = n_step + 5'd1;
                n_phase = (n_phase == PHASE_LAST) ? 2'd0 : n_phase + 2'd1;
            end
        end
    end

    // Sequencer state moves with each beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_cmd     <= OP_NONE;
            r_step    <= '0;
            r_phase   <= '0;
            r_shift   <= '0;
            r_nack    <= 1'b0;
            r_ack     <= 1'b0;
            r_rd_hold <= '0;
        end else if (adv) begin
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_cmd     <= n_cmd;
            r_step    <= n_step;
            r_phase   <= n_phase;
            r_shift   <= n_shift;
            r_nack    <= n_nack;
            r_ack     <= n_ack;
            r_rd_hold <= n_rd_hold;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {3'b000, n_rd_hold, n_ack, n_done,
                           (n_cmd != OP_NONE), n_sda, n_scl};
        end
    end

    // ---------------- assertions ----------------
    // A beat never reports done while still busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[3] && r_out_data[2]))
        else $error("done and busy set in the same beat");

    // Idle sequencer keeps its step counters cleared
    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == OP_NONE) |-> (r_step == '0 && r_phase == '0))
        else $error("step counters not cleared while idle");

    // Step count stays within the longest sequence
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step <= LAST_READ_STEP) && (r_phase <= PHASE_LAST))
        else $error("step counter out of range");

    // Without a beat moving through, the sequencer state holds
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_step) && $stable(r_cmd) && $stable(r_rd_hold)))
        else $error("sequencer state changed without a beat");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
// A generator fills a queue of line ticks: a short directed run (every
// command, byte extremes, ACK/NACK both ways, commands while busy, op 7),
// then random command sequences padded with follow-up ticks, plus noise and
// cut-short sequences. A driver streams the ticks with random gaps, and a
// bus model predicts one result beat per accepted tick. A monitor stalls at
// random and compares every result beat field by field with the oldest
// prediction.
module tb_top;
    import i2c_seq_pkg::*;

    localparam int unsigned N_RANDOM    = 1030;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned TAIL_CYCLES = 20;

    // One input tick; drain marks a pause until all results are back.
    typedef struct packed {
        bit         drain;
        logic       sda;
        logic       nack;
        logic       rflag;
        logic [6:0] addr;
        logic [7:0] wdata;
        logic [2:0] op;
    } t_tick;

    // One result beat, same bit order as o_m_axis_tdata[12:0].
    typedef struct packed {
        logic [7:0] rdata;
        logic       ack_err;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } t_lines;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            tx_valid = 1'b0;
    logic [IN_W-1:0] tx_data = '0;
    logic            rx_ready = 1'b0;
    logic            o_s_axis_tready;
    logic            o_m_axis_tvalid;
    logic [OUT_W-1:0] o_m_axis_tdata;

    i2c_master_bit_sequencer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (tx_valid),
        .o_s_axis_tready (o_s_axis_tready),
        // [2:0] op, [10:3] write_data, [17:11] target_addr, [18] read_flag,
        // [19] send_nack, [20] sda_in, [23:21] zero
        .i_s_axis_tdata  (tx_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (rx_ready),
        // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] ack_error,
        // [12:5] read_data, [15:13] zero
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Bus model state
    // ------------------------------------------------------------------
    logic       bus_scl;
    logic       bus_sda;
    t_op        seq_cmd;
    logic [4:0] seq_step;
    logic [7:0] seq_shift;
    logic       seq_nack;
    logic       seq_ack;
    logic [7:0] seq_rdbyte;

    t_tick  tick_q[$];
    t_lines expected_lines[$];
    int     err_cnt = 0;
    int     n_ticks = 0;
    int     n_checked = 0;

    // Advances the bus model by one tick and returns the line state after it.
    function automatic t_lines step_bus(t_tick t);
        t_lines r;
        logic   last;
        int     k;
        last = 1'b0;
        // Commands only land while idle; their first step runs this tick.
        if (seq_cmd == OP_NONE && t.op >= OP_START && t.op <= OP_READ) begin
            seq_cmd  = t_op'(t.op);
            seq_step = '0;
            case (seq_cmd)
                OP_WRITE: seq_shift = t.wdata;
                OP_ADDR:  seq_shift = {t.addr, t.rflag};
                OP_READ: begin
                    seq_shift = '0;      // read always assembles from zero
                    seq_nack  = t.nack;
                end
                default: ;
            endcase
        end
        if (seq_cmd != OP_NONE) begin
            k = int'(seq_step);
            case (seq_cmd)
                OP_START: begin
                    if (k == 0) bus_sda = 1'b1;
                    else if (k == 1) bus_scl = 1'b1;
                    else bus_sda = 1'b0;
                    last = (k >= 2);
                end
                OP_RSTART: begin
                    if (k == 0) bus_scl = 1'b0;
                    else if (k == 1) bus_sda = 1'b1;
                    else if (k == 2) bus_scl = 1'b1;
                    else bus_sda = 1'b0;
                    last = (k >= 3);
                end
                OP_STOP: begin
                    if (k == 0) bus_scl = 1'b0;
                    else if (k == 1) bus_sda = 1'b0;
                    else if (k == 2) bus_scl = 1'b1;
                    else bus_sda = 1'b1;
                    last = (k >= 3);
                end
                OP_WRITE, OP_ADDR: begin
                    // 8 bits x (SCL low, SDA bit, SCL high), MSB first, then ACK slot
                    if (k < 24) begin
                        case (k % 3)
                            0: bus_scl = 1'b0;
                            1: bus_sda = seq_shift[7 - k / 3];
                            default: bus_scl = 1'b1;
                        endcase
                    end else if (k == 24) bus_scl = 1'b0;
                    else if (k == 25) bus_sda = 1'b1;
                    else if (k == 26) bus_scl = 1'b1;
                    else seq_ack = t.sda;
                    last = (k >= 27);
                end
                OP_READ: begin
                    // 8 bits x (SCL low, SCL high, sample), then drive ACK/NACK
                    if (k < 24) begin
                        case (k % 3)
                            0: bus_scl = 1'b0;
                            1: bus_scl = 1'b1;
                            default: seq_shift = {seq_shift[6:0], t.sda};
                        endcase
                    end else if (k == 24) bus_scl = 1'b0;
                    else if (k == 25) bus_sda = seq_nack;
                    else if (k == 26) bus_scl = 1'b1;
                    else if (k == 27) bus_scl = 1'b0;
                    else begin
                        bus_sda    = 1'b1;
                        seq_rdbyte = seq_shift;
                    end
                    last = (k >= 28);
                end
                default: last = 1'b1;
            endcase
            if (last) begin
                seq_cmd  = OP_NONE;
                seq_step = '0;
            end else begin
                seq_step = seq_step + 5'd1;
            end
        end
        r.scl     = bus_scl;
        r.sda     = bus_sda;
        r.busy    = (seq_cmd != OP_NONE);
        r.done    = last;
        r.ack_err = seq_ack;
        r.rdata   = seq_rdbyte;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Ticks a command needs to run to completion, its own tick included.
    function automatic int seq_len(t_op op);
        case (op)
            OP_START:          return 3;
            OP_RSTART, OP_STOP: return 4;
            OP_WRITE, OP_ADDR: return 28;
            OP_READ:           return 29;
            default:           return 1;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_tick(logic [2:0] op, logic [7:0] wd, logic [6:0] a,
                             logic rf, logic nk, logic sd);
        t_tick t;
        t.drain = 1'b0;
        t.op    = op;
        t.wdata = wd;
        t.addr  = a;
        t.rflag = rf;
        t.nack  = nk;
        t.sda   = sd;
        tick_q.push_back(t);
        n_ticks++;
    endtask

    task automatic push_drain();
        t_tick t;
        t       = '0;
        t.drain = 1'b1;
        tick_q.push_back(t);
    endtask

    // Command beat plus follow-up ticks. sda_mode: 0 low, 1 high, else random.
    // noise: percent of follow-up ticks that carry a (to be ignored) command.
    task automatic push_cmd(t_op op, logic [7:0] wd, logic [6:0] a, logic rf,
                            logic nk, int sda_mode, int noise, int follow);
        logic [2:0] fop;
        logic       sd;
        push_tick(op, wd, a, rf, nk, 1'($urandom_range(0, 1)));
        for (int i = 0; i < follow; i++) begin
            fop = ($urandom_range(0, 99) < noise) ? 3'($urandom_range(1, 7)) : OP_NONE;
            sd  = (sda_mode == 0) ? 1'b0 : (sda_mode == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            push_tick(fop, 8'($urandom), 7'($urandom), 1'($urandom), 1'($urandom), sd);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: feeds ticks from tick_q and predicts each accepted beat
    // ------------------------------------------------------------------
    t_tick cur_tick;
    logic  tx_hold;
    int    tx_gap;
    int    tx_quiet;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bus_scl    = 1'b1;
            bus_sda    = 1'b1;
            seq_cmd    = OP_NONE;
            seq_step   = '0;
            seq_shift  = '0;
            seq_nack   = 1'b0;
            seq_ack    = 1'b0;
            seq_rdbyte = '0;
            tx_gap     = 0;
            tx_quiet   = 0;
            cur_tick   = '0;
            tx_valid   <= 1'b0;
        end else begin
            if (tx_valid && o_s_axis_tready) begin
                expected_lines.push_back(step_bus(cur_tick));
                tx_hold = 1'b0;
            end else begin
                tx_hold = tx_valid;
            end
            if (!tx_hold) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (tick_q.size() > 0) begin
                    if (tick_q[0].drain) begin
                        // hold off until every result beat is back
                        if (expected_lines.size() == 0) void'(tick_q.pop_front());
                    end else begin
                        cur_tick = tick_q.pop_front();
                        tx_hold  = 1'b1;
                        if (tx_quiet > 0) begin
                            tx_quiet--;
                            tx_gap = 0;
                        end else begin
                            tx_gap = pick_gap();
                            if ($urandom_range(0, 19) == 0) tx_quiet = $urandom_range(20, 150);
                        end
                    end
                end
            end
            tx_valid <= tx_hold;
            tx_data  <= {3'b000, cur_tick.sda, cur_tick.nack, cur_tick.rflag,
                         cur_tick.addr, cur_tick.wdata, cur_tick.op};
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, compares every result beat
    // ------------------------------------------------------------------
    t_lines act_lines;
    t_lines exp_lines;
    int     rx_gap;
    int     rx_quiet;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_gap   = 0;
            rx_quiet = 0;
            rx_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && rx_ready) begin
                act_lines = o_m_axis_tdata[12:0];
                if (expected_lines.size() == 0) begin
                    $error("result beat with no tick outstanding: %0h", o_m_axis_tdata);
                    err_cnt++;
                end else begin
                    exp_lines = expected_lines.pop_front();
                    n_checked++;
                    check_field("scl_out",   8'(exp_lines.scl),     8'(act_lines.scl));
                    check_field("sda_out",   8'(exp_lines.sda),     8'(act_lines.sda));
                    check_field("busy_res",  8'(exp_lines.busy),    8'(act_lines.busy));
                    check_field("done_res",  8'(exp_lines.done),    8'(act_lines.done));
                    check_field("ack_error", 8'(exp_lines.ack_err), 8'(act_lines.ack_err));
                    check_field("read_data", exp_lines.rdata,       act_lines.rdata);
                end
            end
            if (rx_quiet > 0) begin
                rx_quiet--;
                rx_ready <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= 1'b1;
                rx_gap = pick_gap();
                if ($urandom_range(0, 24) == 0) rx_quiet = $urandom_range(20, 150);
            end
        end
    end

    // Watchdog
    int cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int   n_directed;
        int   kind;
        t_op  op;
        int   follow;

        // idle ticks, op 7 is treated like none
        push_tick(OP_NONE, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0);
        push_tick(3'd7, 8'hff, 7'h7f, 1'b1, 1'b1, 1'b1);
        push_tick(OP_NONE, 8'hff, 7'h7f, 1'b1, 1'b1, 1'b1);
        // start, address all ones with read bit, ACK from target
        push_cmd(OP_START, 8'h00, 7'h00, 1'b0, 1'b0, 2, 0, 2);
        push_cmd(OP_ADDR, 8'h00, 7'h7f, 1'b1, 1'b0, 0, 0, 27);
        // all-ones byte, target NACKs
        push_cmd(OP_WRITE, 8'hff, 7'h00, 1'b0, 1'b0, 1, 0, 27);
        // all-zeros byte while every follow-up tick tries another command
        push_cmd(OP_WRITE, 8'h00, 7'h00, 1'b0, 1'b0, 0, 100, 27);
        push_cmd(OP_RSTART, 8'h00, 7'h00, 1'b0, 1'b0, 2, 0, 3);
        push_cmd(OP_ADDR, 8'hff, 7'h00, 1'b0, 1'b1, 2, 0, 27);
        // read all ones with ACK, then read after read of all zeros with NACK
        push_cmd(OP_READ, 8'h00, 7'h00, 1'b0, 1'b0, 1, 0, 28);
        push_cmd(OP_READ, 8'h00, 7'h00, 1'b0, 1'b1, 0, 0, 28);
        push_cmd(OP_READ, 8'h00, 7'h00, 1'b0, 1'b0, 2, 0, 28);
        push_cmd(OP_STOP, 8'h00, 7'h00, 1'b0, 1'b0, 2, 0, 3);
        push_tick(3'd7, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0);
        push_drain();
        n_directed = n_ticks;

        while (n_ticks < n_directed + N_RANDOM) begin
            kind = $urandom_range(0, 99);
            op   = t_op'($urandom_range(OP_START, OP_READ));
            if (kind < 80) begin
                // complete sequence with random content
                push_cmd(op, 8'($urandom), 7'($urandom), 1'($urandom), 1'($urandom), 2,
                         ($urandom_range(0, 3) == 0) ? 20 : 0, seq_len(op) - 1);
            end else if (kind < 90) begin
                // idle noise
                push_tick(($urandom_range(0, 1) == 0) ? OP_NONE : 3'd7,
                          8'($urandom), 7'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom));
            end else begin
                // cut-short sequence; the next command may land mid-flight
                follow = $urandom_range(0, seq_len(op) - 1);
                push_cmd(op, 8'($urandom), 7'($urandom), 1'($urandom), 1'($urandom),
                         2, 0, follow);
            end
            if ($urandom_range(0, 39) == 0) push_drain();
        end

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (n_checked < n_ticks)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
